/* hdl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

/* hdl/grtl_pkg.sv */
package grtl_pkg;

  localparam int MAX_GLYPHS = 4096;
  localparam int MAX_RANGES = 256;

  localparam int GIDX_W = $clog2(MAX_GLYPHS);
  localparam int GCNT_W = GIDX_W + 1;
  localparam int RIDX_W = $clog2(MAX_RANGES);
  localparam int RCNT_W = RIDX_W + 1;
  localparam int SRCH_W = RCNT_W + 1;
  localparam int CP_W   = 21;
  localparam int IDX_W  = CP_W + 1;
  localparam int OFF_W  = 24;
  localparam int IN_CP_W = 24;
  localparam int GW_W   = 8;
  localparam int ST_W   = 3;
  localparam int NEXT_W = OFF_W + 2;

  localparam logic [IN_CP_W-1:0] CP_LIMIT    = 24'h110000;
  localparam logic [GW_W-1:0]    WIDTH_LIMIT = 8'd64;
  localparam logic [IN_CP_W-1:0] REPLACEMENT = 24'h00FFFD;
  localparam logic [NEXT_W-1:0]  OFF_MAX     = 26'h0FFFFFF;
  localparam logic [OFF_W-1:0]   WIDTH_BYTE  = 24'd3;
  localparam logic [NEXT_W-1:0]  HDR_BYTES   = 26'd4;
  localparam logic [NEXT_W-1:0]  BYTES_PER_COL = 26'd3;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_REPLACED  = 3'd1;
  localparam logic [ST_W-1:0] ST_DEFAULT   = 3'd2;
  localparam logic [ST_W-1:0] ST_CP_RANGE  = 3'd3;
  localparam logic [ST_W-1:0] ST_WIDTH     = 3'd4;
  localparam logic [ST_W-1:0] ST_ORDER     = 3'd5;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd6;
  localparam logic [ST_W-1:0] ST_CORRUPT   = 3'd7;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [CP_W-1:0]   first;
    logic [CP_W-1:0]   last;
    logic [GCNT_W-1:0] base;
  } range_ent_t;

  typedef struct packed {
    logic              any_loaded;
    logic [CP_W-1:0]   open_last;
    logic [GCNT_W-1:0] glyph_count;
    logic [RCNT_W-1:0] range_count;
    logic [OFF_W-1:0]  byte_offset;
  } load_state_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             gap;
    logic [OFF_W-1:0] next_offset;
  } load_res_t;

endpackage

/* hdl/grtl_if.sv */
interface grtl_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [grtl_pkg::IN_CP_W-1:0]  code_point;
  logic [grtl_pkg::GW_W-1:0]     glyph_width;

  modport source (output valid, func, code_point, glyph_width, input ready);
  modport sink (input valid, func, code_point, glyph_width, output ready);
endinterface

interface grtl_out_if;
  logic                        valid;
  logic                        ready;
  logic [grtl_pkg::ST_W-1:0]   status;
  logic [grtl_pkg::OFF_W-1:0]  glyph_offset;

  modport source (output valid, status, glyph_offset, input ready);
  modport sink (input valid, status, glyph_offset, output ready);
endinterface

/* hdl/grtl_load_check.sv */
module grtl_load_check (
  input  logic [grtl_pkg::IN_CP_W-1:0] code_point,
  input  logic [grtl_pkg::GW_W-1:0]    glyph_width,
  input  grtl_pkg::load_state_t        st,
  output grtl_pkg::load_res_t          chk
);

  logic [grtl_pkg::IN_CP_W-1:0] last_ext;
  logic [grtl_pkg::NEXT_W-1:0]  next_off;
  logic [grtl_pkg::SRCH_W-1:0]  ranges_needed;
  logic                         gap;

  assign last_ext      = grtl_pkg::IN_CP_W'(st.open_last);
  assign gap           = st.any_loaded && ((last_ext + grtl_pkg::IN_CP_W'(1)) < code_point);
  assign ranges_needed = grtl_pkg::SRCH_W'(st.range_count) + grtl_pkg::SRCH_W'(2);
  assign next_off      = grtl_pkg::NEXT_W'(st.byte_offset)
                       + grtl_pkg::NEXT_W'(glyph_width) * grtl_pkg::BYTES_PER_COL
                       + grtl_pkg::HDR_BYTES;

  always_comb begin
    chk.gap         = gap;
    chk.next_offset = next_off[grtl_pkg::OFF_W-1:0];
    if (code_point >= grtl_pkg::CP_LIMIT) begin
      chk.status = grtl_pkg::ST_CP_RANGE;
    end else if (glyph_width > grtl_pkg::WIDTH_LIMIT) begin
      chk.status = grtl_pkg::ST_WIDTH;
    end else if (st.any_loaded && (last_ext >= code_point)) begin
      chk.status = grtl_pkg::ST_ORDER;
    end else if (st.glyph_count >= grtl_pkg::GCNT_W'(grtl_pkg::MAX_GLYPHS)) begin
      chk.status = grtl_pkg::ST_FULL;
    end else if (gap && (ranges_needed > grtl_pkg::SRCH_W'(grtl_pkg::MAX_RANGES))) begin
      chk.status = grtl_pkg::ST_FULL;
    end else if (next_off > grtl_pkg::OFF_MAX) begin
      chk.status = grtl_pkg::ST_FULL;
    end else begin
      chk.status = grtl_pkg::ST_OK;
    end
  end

endmodule

/* hdl/glyph_range_table_lookup.sv */
// Glyph range table. A load transfer (func 0) appends one glyph header and answers with
// the stored width-byte offset or an error code; any error makes the table corrupt, after
// which every transfer answers status 7. A lookup transfer (func 1) binary-searches the
// range memory: each probe goes through the registered read port of the range memory and
// then a compare, a search takes up to 9 probes, a hit goes on to index and fetch the glyph
// offset memory (S_INDEX, then S_FETCH), and a miss repeats the search for U+FFFD. One item
// is worked on at a time; a new item is taken while the previous result still waits in the
// output register. The memories need no clearing after reset: only entries already
// written by loads are ever used.
`include "assert_macros.svh"

module glyph_range_table_lookup (
  input  logic              clk,
  input  logic              rst,
  grtl_in_if.sink           item,
  grtl_out_if.source        result
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_PROBE   = 6'b000010,
    S_COMPARE = 6'b000100,
    S_INDEX   = 6'b001000,
    S_FETCH   = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state;

  logic                           any_loaded;
  logic                           corrupt;
  logic [grtl_pkg::CP_W-1:0]      open_first;
  logic [grtl_pkg::CP_W-1:0]      open_last;
  logic [grtl_pkg::GCNT_W-1:0]    open_base;
  logic [grtl_pkg::GCNT_W-1:0]    glyph_count;
  logic [grtl_pkg::RCNT_W-1:0]    range_count;
  logic [grtl_pkg::OFF_W-1:0]     byte_offset;

  logic [grtl_pkg::IN_CP_W-1:0]   target;
  logic                           retry;
  logic signed [grtl_pkg::SRCH_W-1:0] lo;
  logic signed [grtl_pkg::SRCH_W-1:0] hi;
  logic signed [grtl_pkg::SRCH_W-1:0] mid;
  logic signed [grtl_pkg::SRCH_W-1:0] mid_calc;
  logic signed [grtl_pkg::SRCH_W-1:0] hi_init;
  logic                           mid_closed;
  logic [grtl_pkg::IDX_W-1:0]     idx;

  logic [grtl_pkg::ST_W-1:0]      res_status;
  logic [grtl_pkg::OFF_W-1:0]     res_offset;
  logic                           out_valid;
  logic [grtl_pkg::ST_W-1:0]      out_status;
  logic [grtl_pkg::OFF_W-1:0]     out_offset;

  grtl_pkg::range_ent_t           range_mem [grtl_pkg::MAX_RANGES];
  grtl_pkg::range_ent_t           range_rd;
  grtl_pkg::range_ent_t           range_wd;
  grtl_pkg::range_ent_t           ent;
  logic                           range_we;
  logic                           range_re;

  logic [grtl_pkg::OFF_W-1:0]     glyph_mem [grtl_pkg::MAX_GLYPHS];
  logic [grtl_pkg::OFF_W-1:0]     glyph_rd;
  logic                           glyph_we;
  logic                           glyph_re;

  grtl_pkg::load_state_t          ld_state;
  grtl_pkg::load_res_t            chk;

  logic                           item_xfer;
  logic                           load_ok;
  logic                           miss;
  logic                           out_free;
  logic                           out_load;

  assign ld_state.any_loaded  = any_loaded;
  assign ld_state.open_last   = open_last;
  assign ld_state.glyph_count = glyph_count;
  assign ld_state.range_count = range_count;
  assign ld_state.byte_offset = byte_offset;

  grtl_load_check u_check (
    .code_point  (item.code_point),
    .glyph_width (item.glyph_width),
    .st          (ld_state),
    .chk         (chk)
  );

  assign item.ready    = (state == S_IDLE);
  assign item_xfer     = item.valid && item.ready;
  assign load_ok       = item_xfer && (item.func == grtl_pkg::FUNC_LOAD) && !corrupt
                       && (chk.status == grtl_pkg::ST_OK);

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.glyph_offset = out_offset;
  assign out_free            = !out_valid || result.ready;
  assign out_load            = (state == S_DONE) && out_free;

  // search bounds and probe index
  assign hi_init  = $signed(grtl_pkg::SRCH_W'(range_count) + grtl_pkg::SRCH_W'(any_loaded)
                  - grtl_pkg::SRCH_W'(1));
  assign mid_calc = lo + ((hi - lo) >>> 1);

  assign range_re  = (state == S_PROBE);
  assign range_we  = load_ok && chk.gap;
  assign range_wd  = '{first: open_first, last: open_last, base: open_base};
  assign ent       = mid_closed ? range_rd : '{first: open_first, last: open_last,
                                              base: open_base};

  assign glyph_we  = load_ok;
  assign glyph_re  = (state == S_INDEX);

  assign miss = ((state == S_PROBE) && (lo > hi))
             || ((state == S_INDEX) && (idx >= grtl_pkg::IDX_W'(glyph_count)));

  always_ff @(posedge clk) begin
    if (range_we) begin
      range_mem[range_count[grtl_pkg::RIDX_W-1:0]] <= range_wd;
    end
    if (range_re) begin
      range_rd <= range_mem[mid_calc[grtl_pkg::RIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[glyph_count[grtl_pkg::GIDX_W-1:0]] <= byte_offset + grtl_pkg::WIDTH_BYTE;
    end
    if (glyph_re) begin
      glyph_rd <= glyph_mem[idx[grtl_pkg::GIDX_W-1:0]];
    end
  end

  // table state, written on a good load; a failed load sets corrupt
  always_ff @(posedge clk) begin
    if (rst) begin
      any_loaded  <= 1'b0;
      corrupt     <= 1'b0;
      open_first  <= '0;
      open_last   <= '0;
      open_base   <= '0;
      glyph_count <= '0;
      range_count <= '0;
      byte_offset <= '0;
    end else if (item_xfer && (item.func == grtl_pkg::FUNC_LOAD) && !corrupt) begin
      if (chk.status != grtl_pkg::ST_OK) begin
        corrupt <= 1'b1;
      end else begin
        if (chk.gap) begin
          range_count <= range_count + grtl_pkg::RCNT_W'(1);
        end
        if (chk.gap || !any_loaded) begin
          open_first <= item.code_point[grtl_pkg::CP_W-1:0];
          open_base  <= glyph_count;
        end
        any_loaded  <= 1'b1;
        open_last   <= item.code_point[grtl_pkg::CP_W-1:0];
        glyph_count <= glyph_count + grtl_pkg::GCNT_W'(1);
        byte_offset <= chk.next_offset;
      end
    end
  end

  // control path
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      retry     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        out_status <= res_status;
        out_offset <= res_offset;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      // a miss retries with the replacement character, then falls back to offset 0
      if (miss) begin
        if (!retry && (target != grtl_pkg::REPLACEMENT)) begin
          target <= grtl_pkg::REPLACEMENT;
          retry  <= 1'b1;
          lo     <= '0;
          hi     <= hi_init;
          state  <= S_PROBE;
        end else begin
          res_status <= grtl_pkg::ST_DEFAULT;
          res_offset <= '0;
          state      <= S_DONE;
        end
      end else begin
        case (state)
          S_IDLE: begin
            if (item_xfer) begin
              target <= item.code_point;
              retry  <= 1'b0;
              lo     <= '0;
              hi     <= hi_init;
              if (corrupt) begin
                res_status <= grtl_pkg::ST_CORRUPT;
                res_offset <= '0;
                state      <= S_DONE;
              end else if (item.func == grtl_pkg::FUNC_LOAD) begin
                res_status <= chk.status;
                res_offset <= (chk.status == grtl_pkg::ST_OK)
                            ? byte_offset + grtl_pkg::WIDTH_BYTE : '0;
                state      <= S_DONE;
              end else begin
                state <= S_PROBE;
              end
            end
          end
          S_PROBE: begin
            mid        <= mid_calc;
            mid_closed <= (mid_calc < $signed(grtl_pkg::SRCH_W'(range_count)));
            state      <= S_COMPARE;
          end
          S_COMPARE: begin
            if (target < grtl_pkg::IN_CP_W'(ent.first)) begin
              hi    <= mid - grtl_pkg::SRCH_W'(1);
              state <= S_PROBE;
            end else if (target > grtl_pkg::IN_CP_W'(ent.last)) begin
              lo    <= mid + grtl_pkg::SRCH_W'(1);
              state <= S_PROBE;
            end else begin
              idx   <= grtl_pkg::IDX_W'(ent.base)
                     + grtl_pkg::IDX_W'(target[grtl_pkg::CP_W-1:0] - ent.first);
              state <= S_INDEX;
            end
          end
          S_INDEX: begin
            state <= S_FETCH;
          end
          S_FETCH: begin
            res_status <= retry ? grtl_pkg::ST_REPLACED : grtl_pkg::ST_OK;
            res_offset <= glyph_rd;
            state      <= S_DONE;
          end
          S_DONE: begin
            if (out_free) begin
              state <= S_IDLE;
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  `ASSERT_IMPLIES(a_corrupt_sticky, clk, rst, corrupt, ##1 corrupt)
  `ASSERT_NEVER(a_glyph_count_max, clk, rst,
                glyph_count > grtl_pkg::GCNT_W'(grtl_pkg::MAX_GLYPHS))
  `ASSERT_IMPLIES(a_corrupt_zero_off, clk, rst,
                  out_valid && (out_status == grtl_pkg::ST_CORRUPT), out_offset == '0)

endmodule

/* tb/glyph_table_check.sv */
`timescale 1ns / 1ps
module glyph_table_check
  import grtl_pkg::*;
(
  input  logic clk,
  input  logic rst,
  grtl_in_if   item,
  grtl_out_if  result,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] offset;
  } glyph_answer_t;

  logic [OFF_W-1:0] width_byte_at [MAX_GLYPHS];
  int unsigned span_first [MAX_RANGES];
  int unsigned span_last [MAX_RANGES];
  int unsigned span_base [MAX_RANGES];
  int unsigned n_spans;
  int unsigned open_lo;
  int unsigned open_hi;
  int unsigned n_glyphs;
  int unsigned next_record;
  bit have_glyphs;
  bit broken;

  glyph_answer_t pending_answers[$];

  // closed spans plus the growing one, binary search
  function automatic bit find_offset(input int unsigned cp, output logic [OFF_W-1:0] ofs);
    int lo;
    int hi;
    int mid;
    int unsigned f;
    int unsigned l;
    int unsigned b;
    int unsigned idx;
    lo = 0;
    hi = int'(n_spans) + (have_glyphs ? 1 : 0) - 1;
    ofs = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mid < int'(n_spans)) begin
        f = span_first[mid];
        l = span_last[mid];
        b = span_base[mid];
      end else begin
        f = open_lo;
        l = open_hi;
        b = n_glyphs - (open_hi - open_lo + 1);
      end
      if (cp < f) begin
        hi = mid - 1;
      end else if (cp > l) begin
        lo = mid + 1;
      end else begin
        idx = b + (cp - f);
        if (idx >= n_glyphs) return 1'b0;
        ofs = width_byte_at[idx];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [ST_W-1:0] append_glyph(input int unsigned cp, input int unsigned w,
                                                   output logic [OFF_W-1:0] ofs);
    int unsigned nxt;
    bit gap;
    ofs = '0;
    if (cp >= CP_LIMIT) return ST_CP_RANGE;
    if (w > WIDTH_LIMIT) return ST_WIDTH;
    if (have_glyphs && open_hi >= cp) return ST_ORDER;
    gap = have_glyphs && (open_hi + 1 < cp);
    if (n_glyphs >= MAX_GLYPHS) return ST_FULL;
    if (gap && n_spans + 2 > MAX_RANGES) return ST_FULL;
    nxt = next_record + w * BYTES_PER_COL + HDR_BYTES;
    if (nxt > OFF_MAX) return ST_FULL;
    if (gap) begin
      span_first[n_spans] = open_lo;
      span_last[n_spans] = open_hi;
      span_base[n_spans] = n_glyphs - (open_hi - open_lo + 1);
      n_spans++;
      open_lo = cp;
    end
    if (!have_glyphs) open_lo = cp;
    have_glyphs = 1'b1;
    open_hi = cp;
    ofs = OFF_W'(next_record + WIDTH_BYTE);
    width_byte_at[n_glyphs] = ofs;
    n_glyphs++;
    next_record = nxt;
    return ST_OK;
  endfunction

  function automatic glyph_answer_t predict_answer(input logic f, input int unsigned cp,
                                                   input int unsigned w);
    glyph_answer_t ans;
    logic [OFF_W-1:0] ofs;
    ans.status = ST_OK;
    ans.offset = '0;
    if (broken) begin
      ans.status = ST_CORRUPT;
    end else if (f == FUNC_LOAD) begin
      ans.status = append_glyph(cp, w, ofs);
      if (ans.status != ST_OK) broken = 1'b1;
      else ans.offset = ofs;
    end else if (find_offset(cp, ofs)) begin
      ans.offset = ofs;
    end else if (cp != REPLACEMENT && find_offset(REPLACEMENT, ofs)) begin
      ans.status = ST_REPLACED;
      ans.offset = ofs;
    end else begin
      ans.status = ST_DEFAULT;
    end
    return ans;
  endfunction

  always @(posedge clk) begin
    glyph_answer_t want;
    glyph_answer_t got;
    if (rst) begin
      n_spans = 0;
      open_lo = 0;
      open_hi = 0;
      n_glyphs = 0;
      next_record = 0;
      have_glyphs = 1'b0;
      broken = 1'b0;
      pending_answers.delete();
      mismatches = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.status = result.status;
        got.offset = result.glyph_offset;
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d offset %h", got.status, got.offset);
        end else begin
          want = pending_answers.pop_front();
          if (got.status !== want.status || got.offset !== want.offset) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: status exp %0d got %0d, offset exp %h got %h",
                       want.status, got.status, want.offset, got.offset);
          end
        end
      end
      if (item.valid && item.ready)
        pending_answers.insert(pending_answers.size(),
                               predict_answer(item.func, item.code_point, item.glyph_width));
    end
    outstanding = pending_answers.size();
  end

endmodule

/* tb/tb_glyph_range_table_lookup.sv */
`timescale 1ns / 1ps
module tb_glyph_range_table_lookup;
  import grtl_pkg::*;

  localparam int PACE_MAX = 15;
  localparam int RANDOM_ITEMS = 730;
  localparam int GAP_BUDGET = 240;
  localparam int DRAIN_CYCLES = 80;

  typedef enum int {
    BREAK_CP,
    BREAK_WIDTH,
    BREAK_ORDER,
    BREAK_RANGES
  } break_kind_t;

  logic clk;
  logic rst;
  int mismatches;
  int outstanding;

  int unsigned last_cp = 0;
  bit glyph_seen = 1'b0;
  int n_gaps = 0;
  int unsigned loaded_cps[$];
  bit send_idle = 1'b1;
  bit take_idle = 1'b1;

  grtl_in_if item_bus ();
  grtl_out_if result_bus ();

  glyph_range_table_lookup dut (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus)
  );

  glyph_table_check lookup_check (
    .clk(clk),
    .rst(rst),
    .item(item_bus),
    .result(result_bus),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Verification failed");
    $finish;
  end

  // valid stays high after a transfer until the next call decides
  task automatic send_item(input logic f, input int unsigned cp, input int unsigned w);
    int pause;
    pause = send_idle ? $urandom_range(0, PACE_MAX) : 0;
    if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
    if (pause > 0) begin
      item_bus.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.func <= f;
    item_bus.code_point <= cp[IN_CP_W-1:0];
    item_bus.glyph_width <= w[GW_W-1:0];
    @(posedge clk);
    while (!item_bus.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    item_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic load_glyph(input int unsigned cp, input int unsigned w);
    send_item(FUNC_LOAD, cp, w);
    if (glyph_seen && cp > last_cp + 1) n_gaps++;
    last_cp = cp;
    glyph_seen = 1'b1;
    loaded_cps.insert(loaded_cps.size(), cp);
  endtask

  function automatic int unsigned random_width();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? WIDTH_LIMIT : 0;
    return $urandom_range(0, WIDTH_LIMIT);
  endfunction

  task automatic lookup_random();
    int unsigned cp;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cp = loaded_cps[$urandom_range(0, loaded_cps.size() - 1)];
      4, 5: cp = $urandom_range(0, last_cp + 64);
      6: cp = REPLACEMENT;
      7: cp = $urandom_range(0, 24'hFFFFFF);
      8: cp = $urandom_range(CP_LIMIT, 24'hFFFFFF);
      default: cp = $urandom_range(0, 1) ? 24'h10FFFF : 0;
    endcase
    send_item(FUNC_LOOKUP, cp, $urandom_range(0, 255));
  endtask

  initial begin : result_sink
    int stall;
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = take_idle ? $urandom_range(0, PACE_MAX) : 0;
      if ($urandom_range(0, 39) == 0) take_idle = !take_idle;
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    int i;
    int unsigned cp;
    break_kind_t kind;
    rst <= 1'b1;
    item_bus.valid <= 1'b0;
    item_bus.func <= FUNC_LOAD;
    item_bus.code_point <= '0;
    item_bus.glyph_width <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table
    send_item(FUNC_LOOKUP, 0, 8'hFF);
    send_item(FUNC_LOOKUP, REPLACEMENT, 8'h00);
    send_item(FUNC_LOOKUP, 24'hFFFFFF, 8'h80);
    load_glyph(0, 0);
    load_glyph(1, 64);
    load_glyph(2, 42);
    send_item(FUNC_LOOKUP, 0, 8'h7F);
    send_item(FUNC_LOOKUP, 2, 8'h01);
    send_item(FUNC_LOOKUP, 3, 8'h40);
    // gap closes the first span
    load_glyph(5, 1);
    load_glyph(6, 64);
    send_item(FUNC_LOOKUP, 1, 8'hC3);
    send_item(FUNC_LOOKUP, 6, 8'h3C);
    send_item(FUNC_LOOKUP, 4, 8'hAA);
    send_item(FUNC_LOOKUP, 24'h10FFFF, 8'h55);
    send_item(FUNC_LOOKUP, CP_LIMIT, 8'hFF);
    send_item(FUNC_LOOKUP, 24'h800000, 8'h00);
    load_glyph(9, 21);
    send_item(FUNC_LOOKUP, 5, 8'h10);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if ($urandom_range(0, 99) < 45) begin
        cp = last_cp + 1;
        if ($urandom_range(0, 1) == 1 && n_gaps < GAP_BUDGET && last_cp < 24'h0F0000)
          cp = last_cp + ((last_cp < REPLACEMENT) ? $urandom_range(2, 1500)
                                                  : $urandom_range(2, 20000));
        // make sure the replacement glyph gets loaded
        if (last_cp < REPLACEMENT && cp > REPLACEMENT) cp = REPLACEMENT;
        load_glyph(cp, random_width());
      end else begin
        lookup_random();
      end
    end

    wait_drained();
    kind = break_kind_t'($urandom_range(0, 3));
    case (kind)
      BREAK_RANGES: begin
        while (n_gaps < MAX_RANGES - 1) begin
          if ($urandom_range(0, 7) == 0) lookup_random();
          load_glyph(last_cp + 2, random_width());
        end
        send_item(FUNC_LOAD, last_cp + 2, random_width());
      end
      default: begin
        load_glyph(24'h10FFFF, 64);
        send_item(FUNC_LOOKUP, 24'h10FFFF, 8'h00);
        case (kind)
          BREAK_CP: send_item(FUNC_LOAD, $urandom_range(CP_LIMIT, 24'hFFFFFF), random_width());
          BREAK_WIDTH: send_item(FUNC_LOAD, $urandom_range(0, CP_LIMIT - 1),
                                 $urandom_range(WIDTH_LIMIT + 1, 255));
          default: send_item(FUNC_LOAD, $urandom_range(0, 24'h10FFFF), random_width());
        endcase
      end
    endcase

    // table is corrupt from here on
    for (i = 0; i < 16; i++) begin
      if ($urandom_range(0, 1) == 1) lookup_random();
      else send_item(FUNC_LOAD, $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 255));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
